FILE: design/crt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_pkg
// Types, register map and helper functions shared by the cyclic relay timer.
// ----------------------------------------------------------------------------
package crt_pkg;

	// register map
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;
	localparam int LEN_W      = 16;
	localparam int CNT_W      = 8;
	localparam int MODE_W     = 2;
	localparam int NUM_MODES  = 3;

	localparam logic [2:0] REG_ON_LEN0   = 3'd0;
	localparam logic [2:0] REG_ON_LEN1   = 3'd1;
	localparam logic [2:0] REG_ON_LEN2   = 3'd2;
	localparam logic [2:0] REG_OFF_LEN0  = 3'd3;
	localparam logic [2:0] REG_OFF_LEN1  = 3'd4;
	localparam logic [2:0] REG_OFF_LEN2  = 3'd5;
	localparam logic [2:0] REG_THRESHOLD = 3'd6;

	// reset values of the length and threshold registers
	localparam logic [LEN_W-1:0] LEN0_RST   = 16'd660;
	localparam logic [LEN_W-1:0] LEN1_RST   = 16'd3300;
	localparam logic [LEN_W-1:0] LEN2_RST   = 16'd6600;
	localparam logic [CNT_W-1:0] THRESH_RST = 8'd3;

	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LAST  = 2'd2;

	// configuration seen by the timing logic
	typedef struct packed {
		logic [NUM_MODES-1:0][LEN_W-1:0] on_len;
		logic [NUM_MODES-1:0][LEN_W-1:0] off_len;
		logic [CNT_W-1:0]                threshold;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic              relay_level;
		logic [MODE_W-1:0] on_mode;
		logic [MODE_W-1:0] off_mode;
		logic              mode_changed;
	} res_t;

	// advance a mode, wrapping after the last one
	function automatic logic [MODE_W-1:0] next_mode(input logic [MODE_W-1:0] m);
		logic [MODE_W-1:0] r;
		if (m >= MODE_LAST) begin
			r = MODE_FIRST;
		end else begin
			r = m + 2'd1;
		end
		return r;
	endfunction

	// a mode beyond the last one picks the last length
	function automatic logic [MODE_W-1:0] clamp_mode(input logic [MODE_W-1:0] m);
		return (m > MODE_LAST) ? MODE_LAST : m;
	endfunction

endpackage

FILE: design/crt_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_regs
// APB register file holding the phase lengths and the press threshold.
// ----------------------------------------------------------------------------
module crt_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [crt_pkg::ADDR_W-1:0]    paddr,
	input  logic [crt_pkg::DATA_W-1:0]    pwdata,
	output logic [crt_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	output crt_pkg::cfg_t                 cfg
);
	import crt_pkg::*;

	logic       wr_en;
	logic [2:0] idx;
	cfg_t       cfg_q;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_len[0]  <= LEN0_RST;
			cfg_q.on_len[1]  <= LEN1_RST;
			cfg_q.on_len[2]  <= LEN2_RST;
			cfg_q.off_len[0] <= LEN0_RST;
			cfg_q.off_len[1] <= LEN1_RST;
			cfg_q.off_len[2] <= LEN2_RST;
			cfg_q.threshold  <= THRESH_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_ON_LEN0:   cfg_q.on_len[0]  <= pwdata[LEN_W-1:0];
				REG_ON_LEN1:   cfg_q.on_len[1]  <= pwdata[LEN_W-1:0];
				REG_ON_LEN2:   cfg_q.on_len[2]  <= pwdata[LEN_W-1:0];
				REG_OFF_LEN0:  cfg_q.off_len[0] <= pwdata[LEN_W-1:0];
				REG_OFF_LEN1:  cfg_q.off_len[1] <= pwdata[LEN_W-1:0];
				REG_OFF_LEN2:  cfg_q.off_len[2] <= pwdata[LEN_W-1:0];
				REG_THRESHOLD: cfg_q.threshold  <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// read back, unmapped addresses read as zero
	always_comb begin
		unique case (idx)
			REG_ON_LEN0:   prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_q.on_len[0]};
			REG_ON_LEN1:   prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_q.on_len[1]};
			REG_ON_LEN2:   prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_q.on_len[2]};
			REG_OFF_LEN0:  prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_q.off_len[0]};
			REG_OFF_LEN1:  prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_q.off_len[1]};
			REG_OFF_LEN2:  prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_q.off_len[2]};
			REG_THRESHOLD: prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_q.threshold};
			default:       prdata = '0;
		endcase
	end

endmodule

FILE: design/crt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_core
// Phase, tick and press counters with the mode registers; one tick per fire.
// ----------------------------------------------------------------------------
module crt_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic           change_pin,
	input  logic           select_pin,
	input  crt_pkg::cfg_t  cfg,
	output crt_pkg::res_t  res
);
	import crt_pkg::*;

	logic              off_phase_q;
	logic [LEN_W-1:0]  tick_q;
	logic [CNT_W-1:0]  press_q;
	logic [MODE_W-1:0] on_mode_q;
	logic [MODE_W-1:0] off_mode_q;

	logic              off_phase_d;
	logic [LEN_W-1:0]  tick_d;
	logic [CNT_W-1:0]  press_d;
	logic [MODE_W-1:0] on_mode_d;
	logic [MODE_W-1:0] off_mode_d;

	logic [CNT_W-1:0]  press_inc;
	logic [CNT_W-1:0]  thr;
	logic [LEN_W-1:0]  tick_inc;
	logic [MODE_W-1:0] cur_mode;
	logic [LEN_W-1:0]  raw_len;
	logic [LEN_W-1:0]  len;
	logic              trig;

	// press count and threshold check, zero threshold acts as one
	assign press_inc = change_pin ? press_q + 8'd1 : press_q;
	assign thr       = (cfg.threshold == '0) ? 8'd1 : cfg.threshold;
	assign trig      = (press_inc >= thr);

	// length of the current phase, zero length acts as one
	assign cur_mode = clamp_mode(off_phase_q ? off_mode_q : on_mode_q);
	assign raw_len  = off_phase_q ? cfg.off_len[cur_mode] : cfg.on_len[cur_mode];
	assign len      = (raw_len == '0) ? 16'd1 : raw_len;
	assign tick_inc = tick_q + 16'd1;

	// next state for this tick
	always_comb begin
		off_phase_d = off_phase_q;
		tick_d      = tick_inc;
		press_d     = press_inc;
		on_mode_d   = on_mode_q;
		off_mode_d  = off_mode_q;
		priority if (trig) begin
			tick_d      = '0;
			press_d     = '0;
			off_phase_d = 1'b0;
			if (select_pin) begin
				on_mode_d = next_mode(on_mode_q);
			end else begin
				off_mode_d = next_mode(off_mode_q);
			end
		end else if (tick_inc >= len) begin
			tick_d      = '0;
			press_d     = '0;
			off_phase_d = ~off_phase_q;
		end else begin
			// mid phase: keep counting
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_phase_q <= 1'b0;
			tick_q      <= '0;
			press_q     <= '0;
			on_mode_q   <= MODE_FIRST;
			off_mode_q  <= MODE_FIRST;
		end else if (fire) begin
			off_phase_q <= off_phase_d;
			tick_q      <= tick_d;
			press_q     <= press_d;
			on_mode_q   <= on_mode_d;
			off_mode_q  <= off_mode_d;
		end
	end

	// result of this tick
	assign res.relay_level  = off_phase_d;
	assign res.on_mode      = on_mode_d;
	assign res.off_mode     = off_mode_d;
	assign res.mode_changed = trig;

endmodule

FILE: design/cyclic_relay_timer.sv
`timescale 1ns / 1ps
// Path: an accepted item passes the input register, then the result register;
// a full result register held by out_ready low also holds the item in the input register.
// Throughput: one item per cycle while out_ready does not hold the result register.
// Reset: arst_n clears the phase, counters, modes and valid flags at once and
// loads the length and threshold registers with their defaults.
// ----------------------------------------------------------------------------
// cyclic_relay_timer
// Cyclic relay timer stepped by one tick item, with APB configuration.
// ----------------------------------------------------------------------------
module cyclic_relay_timer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          change_pin,
	input  logic                          select_pin,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          relay_level,
	output logic [crt_pkg::MODE_W-1:0]    on_mode,
	output logic [crt_pkg::MODE_W-1:0]    off_mode,
	output logic                          mode_changed,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [crt_pkg::ADDR_W-1:0]    paddr,
	input  logic [crt_pkg::DATA_W-1:0]    pwdata,
	output logic [crt_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import crt_pkg::*;

	cfg_t cfg;
	res_t res;
	res_t res_s2;
	logic valid_s1;
	logic valid_s2;
	logic change_s1;
	logic select_s1;
	logic advance;
	logic fire;

	// configuration registers
	crt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake: stage 1 moves on when the result register is free or drains
	assign advance  = ~valid_s2 | out_ready;
	assign fire     = valid_s1 & advance;
	assign in_ready = ~valid_s1 | advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			change_s1 <= change_pin;
			select_s1 <= select_pin;
		end
	end

	// timing logic
	crt_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.change_pin (change_s1),
		.select_pin (select_s1),
		.cfg        (cfg),
		.res        (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign relay_level  = res_s2.relay_level;
	assign on_mode      = res_s2.on_mode;
	assign off_mode     = res_s2.off_mode;
	assign mode_changed = res_s2.mode_changed;

endmodule

FILE: verif/cyclic_relay_timer_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyclic_relay_timer_chk
// Watches the tick, result and APB channels of the cyclic relay timer. It
// keeps its own copy of the timer state and the register file, works out
// the expected result for every accepted tick item and compares each
// accepted result field by field with the oldest one still pending.
// ----------------------------------------------------------------------------
module cyclic_relay_timer_chk (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic                       change_pin,
	input  logic                       select_pin,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic                       relay_level,
	input  logic [crt_pkg::MODE_W-1:0] on_mode,
	input  logic [crt_pkg::MODE_W-1:0] off_mode,
	input  logic                       mode_changed,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [crt_pkg::ADDR_W-1:0] paddr,
	input  logic [crt_pkg::DATA_W-1:0] pwdata,
	output int                         errors,
	output int                         backlog
);
	import crt_pkg::*;

	// shadow registers and timer state
	cfg_t              timing;
	logic              off_phase;
	logic [LEN_W-1:0]  tick_run;
	logic [CNT_W-1:0]  press_run;
	logic [MODE_W-1:0] on_sel;
	logic [MODE_W-1:0] off_sel;

	res_t relay_forecast [$];
	res_t due;
	int   fail_tally = 0;
	int   pending_now = 0;

	assign errors  = fail_tally;
	assign backlog = pending_now;

	task automatic report_mismatch(input string what, input int got, input int want);
		fail_tally++;
		if (fail_tally <= 40) begin
			$display("[%0t] relay check: %s got %0d want %0d", $time, what, got, want);
		end
	endtask

	function automatic logic [MODE_W-1:0] bump_mode(input logic [MODE_W-1:0] m);
		return (m >= MODE_LAST) ? MODE_FIRST : m + 2'd1;
	endfunction

	// one tick of the timer; updates the shadow state and returns the result
	function automatic res_t advance_timer(input logic chg, input logic sel);
		res_t              r;
		logic [CNT_W-1:0]  thr;
		logic [MODE_W-1:0] m;
		logic [LEN_W-1:0]  span;
		thr = (timing.threshold == '0) ? 8'd1 : timing.threshold;
		r.mode_changed = 1'b0;
		if (chg) begin
			press_run = press_run + 8'd1;
		end
		if (press_run >= thr) begin
			// enough presses: advance the selected mode and restart at on phase
			press_run = '0;
			tick_run  = '0;
			if (sel) begin
				on_sel = bump_mode(on_sel);
			end else begin
				off_sel = bump_mode(off_sel);
			end
			off_phase      = 1'b0;
			r.mode_changed = 1'b1;
		end else begin
			tick_run = tick_run + 16'd1;
			m = off_phase ? off_sel : on_sel;
			if (m > MODE_LAST) begin
				m = MODE_LAST;
			end
			span = off_phase ? timing.off_len[m] : timing.on_len[m];
			if (span == '0) begin
				span = 16'd1;
			end
			// end of phase: toggle and start counting afresh
			if (tick_run >= span) begin
				tick_run  = '0;
				press_run = '0;
				off_phase = ~off_phase;
			end
		end
		r.relay_level = off_phase;
		r.on_mode     = on_sel;
		r.off_mode    = off_sel;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing.on_len[0]  = LEN0_RST;
			timing.on_len[1]  = LEN1_RST;
			timing.on_len[2]  = LEN2_RST;
			timing.off_len[0] = LEN0_RST;
			timing.off_len[1] = LEN1_RST;
			timing.off_len[2] = LEN2_RST;
			timing.threshold  = THRESH_RST;
			off_phase = 1'b0;
			tick_run  = '0;
			press_run = '0;
			on_sel    = MODE_FIRST;
			off_sel   = MODE_FIRST;
			relay_forecast.delete();
			pending_now <= 0;
		end else begin
			// register writes, masked to the register width
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_ON_LEN0:   timing.on_len[0]  = pwdata[LEN_W-1:0];
					REG_ON_LEN1:   timing.on_len[1]  = pwdata[LEN_W-1:0];
					REG_ON_LEN2:   timing.on_len[2]  = pwdata[LEN_W-1:0];
					REG_OFF_LEN0:  timing.off_len[0] = pwdata[LEN_W-1:0];
					REG_OFF_LEN1:  timing.off_len[1] = pwdata[LEN_W-1:0];
					REG_OFF_LEN2:  timing.off_len[2] = pwdata[LEN_W-1:0];
					REG_THRESHOLD: timing.threshold  = pwdata[CNT_W-1:0];
					default: ;
				endcase
			end
			// accepted tick item
			if (in_valid && in_ready) begin
				relay_forecast.push_back(advance_timer(change_pin, select_pin));
			end
			// accepted result item
			if (out_valid && out_ready) begin
				if (relay_forecast.size() == 0) begin
					report_mismatch("result with no tick pending", 1, 0);
				end else begin
					due = relay_forecast.pop_front();
					if (relay_level !== due.relay_level) begin
						report_mismatch("relay_level", relay_level, due.relay_level);
					end
					if (on_mode !== due.on_mode) begin
						report_mismatch("on_mode", on_mode, due.on_mode);
					end
					if (off_mode !== due.off_mode) begin
						report_mismatch("off_mode", off_mode, due.off_mode);
					end
					if (mode_changed !== due.mode_changed) begin
						report_mismatch("mode_changed", mode_changed, due.mode_changed);
					end
				end
			end
			pending_now <= relay_forecast.size();
		end
	end

endmodule

FILE: verif/cyclic_relay_timer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cyclic_relay_timer_tb
// Drives tick items and APB register writes into the cyclic relay timer,
// with random bursts of idle on both channels. A directed run covers the
// default setting, mode wrap, zero lengths and threshold, an unmapped
// register and the largest values; random phases follow, each with a new
// register setting. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module cyclic_relay_timer_tb;
	import crt_pkg::*;

	// index past the last register, writes there must be ignored
	localparam logic [2:0] REG_SPARE = 3'd7;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              change_pin = 1'b0;
	logic              select_pin = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b1;
	logic              relay_level;
	logic [MODE_W-1:0] on_mode;
	logic [MODE_W-1:0] off_mode;
	logic              mode_changed;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int fail_count;
	int awaiting;
	int stall_odds = 0;
	int stall_left = 0;
	int gap_odds = 0;

	always #10 clk = ~clk;

	cyclic_relay_timer DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.change_pin(change_pin), .select_pin(select_pin),
		.out_valid(out_valid), .out_ready(out_ready),
		.relay_level(relay_level), .on_mode(on_mode), .off_mode(off_mode),
		.mode_changed(mode_changed),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	cyclic_relay_timer_chk checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.change_pin(change_pin), .select_pin(select_pin),
		.out_valid(out_valid), .out_ready(out_ready),
		.relay_level(relay_level), .on_mode(on_mode), .off_mode(off_mode),
		.mode_changed(mode_changed),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.errors(fail_count), .backlog(awaiting)
	);

	// result side back-pressure in random bursts
	always @(negedge clk) begin
		if (stall_left == 0 && stall_odds != 0 && $urandom_range(0, stall_odds * 3) == 0) begin
			stall_left = $urandom_range(1, 16);
		end
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// present one tick item and hold it until taken
	task automatic send_tick(input logic chg, input logic sel);
		@(negedge clk);
		in_valid   <= 1'b1;
		change_pin <= chg;
		select_pin <= sel;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic rest(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// stop sending and let every pending result come out
	task automatic wait_drained();
		rest(1);
		while (awaiting != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// all six lengths then the threshold, with junk in the unused upper bits
	task automatic program_timer(input logic [5:0][LEN_W-1:0] lens,
			input logic [CNT_W-1:0] thr);
		logic [DATA_W-1:0] junk;
		int k;
		for (k = 0; k < 6; k++) begin
			junk = $urandom;
			write_reg(REG_ON_LEN0 + 3'(k), {junk[DATA_W-1:LEN_W], lens[k]});
		end
		junk = $urandom;
		write_reg(REG_THRESHOLD, {junk[DATA_W-1:CNT_W], thr});
	endtask

	// new register setting, then a run of random tick items
	task automatic random_phase(input int count, input bit calm);
		logic [5:0][LEN_W-1:0] lens;
		logic [CNT_W-1:0]      thr;
		int press_pct;
		int sel_pct;
		int k;
		int n;
		for (k = 0; k < 6; k++) begin
			case ($urandom_range(0, 15))
				0:       lens[k] = '0;
				1:       lens[k] = 16'hFFFF;
				default: lens[k] = LEN_W'($urandom_range(1, 12));
			endcase
		end
		case ($urandom_range(0, 11))
			0:       thr = '0;
			1:       thr = 8'hFF;
			default: thr = CNT_W'($urandom_range(1, 6));
		endcase
		wait_drained();
		program_timer(lens, thr);
		press_pct  = $urandom_range(15, 85);
		sel_pct    = $urandom_range(10, 90);
		gap_odds   = calm ? 0 : $urandom_range(0, 6);
		stall_odds = calm ? 0 : $urandom_range(0, 6);
		for (n = 0; n < count; n++) begin
			send_tick($urandom_range(0, 99) < press_pct, $urandom_range(0, 99) < sel_pct);
			if (gap_odds != 0 && $urandom_range(0, gap_odds * 2) == 0) begin
				rest($urandom_range(1, 16));
			end
		end
	endtask

	initial begin
		int ph;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default setting: plain ticks, then both modes wrapping round
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		repeat (9) send_tick(1'b1, 1'b1);
		repeat (9) send_tick(1'b1, 1'b0);
		wait_drained();

		// zero lengths and zero threshold, plus a write to an unmapped index
		program_timer('0, '0);
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		wait_drained();

		// largest lengths and threshold
		program_timer({6{16'hFFFF}}, 8'hFF);
		repeat (30) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

		for (ph = 0; ph < 10; ph++) begin
			random_phase(60, ph == 9);
		end

		wait_drained();
		repeat (4) @(negedge clk);
		if (fail_count == 0 && awaiting == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// watchdog
	initial begin
		#8_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
